// File: sv/atrw_pkg.sv
// ----------------------------------------------------------------------------
// atrw_pkg
// Types and constants used by the average true range core.
// ----------------------------------------------------------------------------
package atrw_pkg;

    localparam int PRICE_W  = 32;
    localparam int PERIOD_W = 8;
    localparam int SUM_W    = PRICE_W + PERIOD_W;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [0:0] REG_SMOOTHING_PERIOD = 1'b0;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);

    localparam logic [1:0] MODE_WARM   = 2'd0;
    localparam logic [1:0] MODE_HIT    = 2'd1;
    localparam logic [1:0] MODE_SMOOTH = 2'd2;

    typedef struct packed {
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
        logic [PRICE_W-1:0] bar_close;
        logic               series_start;
    } bar_in_t;

    typedef struct packed {
        logic [PRICE_W-1:0] range_average;
        logic               average_valid;
    } atr_out_t;

endpackage

// File: sv/average_true_range_wilder_core.sv
// ----------------------------------------------------------------------------
// average_true_range_wilder_core
// Average true range of a bar stream with Wilder smoothing.
// ----------------------------------------------------------------------------
// One bar is processed at a time. A smoothed bar runs through the true range
// steps (high minus low, distance of the high to the previous close and its
// maximum, then distance of the low and its maximum), a bit-serial multiply
// with its start and finish states, one add, and a restoring divide that
// produces one quotient bit per cycle. The done state then loads the output
// register once it is free. The bar that completes the first period skips the
// multiply, and a first bar also skips the distance steps. The other warmup
// bars skip the divide. The core accepts again in the cycle after a result is
// loaded, so a new bar is taken only after the last one's result is loaded. A
// finished result sits in the output register, so the next bar is taken while
// it waits; a second finished result holds the core until the first one leaves.
// The smoothing period is written over the APB port at byte address 0; the
// user must write it only while the core is idle, which the core itself does
// not enforce. A period of zero acts as one.
module average_true_range_wilder_core
    import atrw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  bar_in_t               s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output atr_out_t              m_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_TR_HL    = 4'd1;
    localparam logic [3:0] ST_DIST_H   = 4'd2;
    localparam logic [3:0] ST_MAX_H    = 4'd3;
    localparam logic [3:0] ST_DIST_L   = 4'd4;
    localparam logic [3:0] ST_MAX_L    = 4'd5;
    localparam logic [3:0] ST_MUL_GO   = 4'd6;
    localparam logic [3:0] ST_MUL_WAIT = 4'd7;
    localparam logic [3:0] ST_ADD      = 4'd8;
    localparam logic [3:0] ST_DIV_GO   = 4'd9;
    localparam logic [3:0] ST_DIV_WAIT = 4'd10;
    localparam logic [3:0] ST_DONE     = 4'd11;

    logic [3:0]          state_reg, state_next;

    logic [PERIOD_W-1:0] period_reg;
    logic [PRICE_W-1:0]  prev_close_reg;
    logic [SUM_W-1:0]    range_sum_reg;
    logic [PRICE_W-1:0]  cur_avg_reg;
    logic [PERIOD_W-1:0] bars_seen_reg;

    logic [PRICE_W-1:0]  hi_reg, lo_reg, cl_reg;
    logic                first_reg;
    logic [1:0]          mode_reg;
    logic [PERIOD_W:0]   n_reg;
    logic [PERIOD_W-1:0] p_reg;
    logic [SUM_W-1:0]    base_sum_reg;
    logic [PRICE_W-1:0]  tr_reg;
    logic [PRICE_W-1:0]  dist_reg;
    logic [SUM_W-1:0]    acc_reg;

    logic                m_valid_reg;
    atr_out_t            m_data_reg;

    logic                s_fire;
    logic                out_load;
    logic                cfg_write;
    logic [PERIOD_W-1:0] p_eff;
    logic [PERIOD_W-1:0] bars_eff;
    logic [PERIOD_W:0]   n_in;
    logic [1:0]          mode_in;
    logic [PRICE_W:0]    hl_diff;
    logic [PRICE_W-1:0]  dist_op;
    logic [PRICE_W:0]    fwd_diff;
    logic [PRICE_W-1:0]  dist_val;

    logic                mul_start, mul_done;
    logic [SUM_W-1:0]    mul_product;
    logic                div_start, div_done;
    logic [SUM_W-1:0]    div_quot;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[APB_ADDR_W-1:2] == REG_SMOOTHING_PERIOD);
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_SMOOTHING_PERIOD)
                       ? {{(APB_DATA_W-PERIOD_W){1'b0}}, period_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
        end else if (cfg_write) begin
            period_reg <= pwdata[PERIOD_W-1:0];
        end
    end

    // transaction classification at acceptance
    assign p_eff    = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign bars_eff = s_data.series_start ? '0 : bars_seen_reg;
    assign n_in     = {1'b0, bars_eff} + 1'b1;

    always_comb begin
        if (n_in < {1'b0, p_eff}) begin
            mode_in = MODE_WARM;
        end else if (n_in == {1'b0, p_eff}) begin
            mode_in = MODE_HIT;
        end else begin
            mode_in = MODE_SMOOTH;
        end
    end

    // shared true range subtractors
    assign hl_diff  = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign dist_op  = (state_reg == ST_DIST_H) ? hi_reg : lo_reg;
    assign fwd_diff = {1'b0, dist_op} - {1'b0, prev_close_reg};
    assign dist_val = fwd_diff[PRICE_W] ? (prev_close_reg - dist_op)
                                        : fwd_diff[PRICE_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_TR_HL;
            end
            ST_TR_HL:    state_next = first_reg ? ST_ADD : ST_DIST_H;
            ST_DIST_H:   state_next = ST_MAX_H;
            ST_MAX_H:    state_next = ST_DIST_L;
            ST_DIST_L:   state_next = ST_MAX_L;
            ST_MAX_L:    state_next = (mode_reg == MODE_SMOOTH) ? ST_MUL_GO : ST_ADD;
            ST_MUL_GO:   state_next = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_done) state_next = ST_ADD;
            end
            ST_ADD:      state_next = (mode_reg == MODE_WARM) ? ST_DONE : ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    assign mul_start = (state_reg == ST_MUL_GO);
    assign div_start = (state_reg == ST_DIV_GO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_close_reg <= '0;
            range_sum_reg  <= '0;
            cur_avg_reg    <= '0;
            bars_seen_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg    <= 1'b1;
                prev_close_reg <= cl_reg;
                if (mode_reg == MODE_WARM) begin
                    range_sum_reg <= acc_reg;
                    bars_seen_reg <= n_reg[PERIOD_W-1:0];
                end else begin
                    if (mode_reg == MODE_HIT) range_sum_reg <= acc_reg;
                    cur_avg_reg   <= div_quot[PRICE_W-1:0];
                    bars_seen_reg <= p_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hi_reg       <= s_data.bar_high;
            lo_reg       <= s_data.bar_low;
            cl_reg       <= s_data.bar_close;
            first_reg    <= (bars_eff == '0);
            mode_reg     <= mode_in;
            n_reg        <= n_in;
            p_reg        <= p_eff;
            base_sum_reg <= s_data.series_start ? '0 : range_sum_reg;
        end
        if (state_reg == ST_TR_HL) begin
            tr_reg <= hl_diff[PRICE_W] ? '0 : hl_diff[PRICE_W-1:0];
        end
        if (state_reg == ST_DIST_H || state_reg == ST_DIST_L) begin
            dist_reg <= dist_val;
        end
        if ((state_reg == ST_MAX_H || state_reg == ST_MAX_L) && dist_reg > tr_reg) begin
            tr_reg <= dist_reg;
        end
        if (state_reg == ST_ADD) begin
            acc_reg <= ((mode_reg == MODE_SMOOTH) ? mul_product : base_sum_reg)
                       + {{PERIOD_W{1'b0}}, tr_reg};
        end
        if (out_load) begin
            if (mode_reg == MODE_WARM) begin
                m_data_reg.range_average <= '0;
                m_data_reg.average_valid <= 1'b0;
            end else begin
                m_data_reg.range_average <= div_quot[PRICE_W-1:0];
                m_data_reg.average_valid <= 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    atrw_serial_mul #(
        .A_W (PRICE_W),
        .B_W (PERIOD_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (cur_avg_reg),
        .mplier  (p_reg - 1'b1),
        .product (mul_product),
        .done    (mul_done)
    );

    atrw_serial_div #(
        .N_W (SUM_W),
        .D_W (PERIOD_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (p_reg),
        .quotient (div_quot),
        .done     (div_done)
    );

`ifndef SYNTH
    a_warm_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.average_valid |-> m_data_reg.range_average == '0)
        else $error("warmup result carries a nonzero average");
    a_quot_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && mode_reg != MODE_WARM
        |-> div_quot[SUM_W-1:PRICE_W] == '0)
        else $error("average does not fit the price width");
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ST_TR_HL)
        else $error("accepted transaction not started");
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL_WAIT |-> mode_reg == MODE_SMOOTH)
        else $error("multiply run outside smoothing");
`endif

endmodule

// File: sv/atrw_serial_mul.sv
// ----------------------------------------------------------------------------
// atrw_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, msb first.
// ----------------------------------------------------------------------------
module atrw_serial_mul #(
    parameter int A_W = 32,
    parameter int B_W = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [A_W-1:0]     mcand,
    input  logic [B_W-1:0]     mplier,
    output logic [A_W+B_W-1:0] product,
    output logic               done
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg;
    logic [A_W-1:0]   mcand_reg;
    logic [B_W-1:0]   mplier_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [P_W-1:0]   addend;

    assign addend = mplier_reg[B_W-1] ? {{B_W{1'b0}}, mcand_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(B_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= '0;
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
        end else if (busy_reg) begin
            acc_reg    <= {acc_reg[P_W-2:0], 1'b0} + addend;
            mplier_reg <= {mplier_reg[B_W-2:0], 1'b0};
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("multiplier done without a run");
    a_cnt_nonzero_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("multiplier busy with empty count");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("multiplier restarted while busy");
`endif

endmodule

// File: sv/atrw_serial_div.sv
// ----------------------------------------------------------------------------
// atrw_serial_div
// Restoring divider, one quotient bit per cycle, dividend shifted msb first.
// ----------------------------------------------------------------------------
module atrw_serial_div #(
    parameter int N_W = 40,
    parameter int D_W = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [N_W-1:0] quotient,
    output logic           done
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     shifted;
    logic [D_W+1:0]   diff;

    assign shifted = {rem_reg, quo_reg[N_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[D_W+1]) begin
                rem_reg <= diff[D_W-1:0];
                quo_reg <= {quo_reg[N_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[D_W-1:0];
                quo_reg <= {quo_reg[N_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg < div_reg)
        else $error("partial remainder not below divisor");
    a_divisor_held: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && $past(busy_reg) && !$past(start) |-> $stable(div_reg))
        else $error("divisor changed during a run");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
`endif

endmodule
